// ===== hdl/ttb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants for the tilt-to-button detector.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int LVL_W = 8;
  localparam int EV_W  = 3;
  localparam int NUM_REGS = 8;
  localparam int IDX_W = 3;

  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [EV_W-1:0]  ev_t;

  typedef enum logic [2:0] {
    MODE_CHECK    = 3'd0,
    MODE_NEG_CONF = 3'd1,
    MODE_NEG_REL  = 3'd2,
    MODE_POS_CONF = 3'd3,
    MODE_POS_REL  = 3'd4
  } mode_t;

  localparam ev_t EV_NONE    = 3'd0;
  localparam ev_t EV_NEG_PR  = 3'd1;
  localparam ev_t EV_NEG_REL = 3'd2;
  localparam ev_t EV_POS_PR  = 3'd3;
  localparam ev_t EV_POS_REL = 3'd4;

  localparam logic [IDX_W-1:0] REG_X_LOW_ENTER    = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_HIGH_ENTER   = 3'd1;
  localparam logic [IDX_W-1:0] REG_X_LOW_CONFIRM  = 3'd2;
  localparam logic [IDX_W-1:0] REG_X_HIGH_CONFIRM = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_LOW_ENTER    = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_HIGH_ENTER   = 3'd5;
  localparam logic [IDX_W-1:0] REG_Y_LOW_CONFIRM  = 3'd6;
  localparam logic [IDX_W-1:0] REG_Y_HIGH_CONFIRM = 3'd7;

  localparam lvl_t RST_X_LOW_ENTER    = 8'd69;
  localparam lvl_t RST_X_HIGH_ENTER   = 8'd212;
  localparam lvl_t RST_X_LOW_CONFIRM  = 8'd56;
  localparam lvl_t RST_X_HIGH_CONFIRM = 8'd218;
  localparam lvl_t RST_Y_LOW_ENTER    = 8'd64;
  localparam lvl_t RST_Y_HIGH_ENTER   = 8'd192;
  localparam lvl_t RST_Y_LOW_CONFIRM  = 8'd51;
  localparam lvl_t RST_Y_HIGH_CONFIRM = 8'd205;

  localparam lvl_t LEVEL_CENTER = 8'd128;

  localparam lvl_t X_NEG_RELEASE = 8'd115;
  localparam lvl_t X_POS_RELEASE = 8'd161;
  localparam lvl_t Y_NEG_RELEASE = 8'd102;
  localparam lvl_t Y_POS_RELEASE = 8'd161;

  typedef struct packed {
    lvl_t lo_enter;
    lvl_t hi_enter;
    lvl_t lo_conf;
    lvl_t hi_conf;
    lvl_t neg_rel;
    lvl_t pos_rel;
  } axis_cfg_t;

  typedef struct packed {
    ev_t  x_event;
    ev_t  y_event;
    lvl_t x_now;
    lvl_t y_now;
  } result_t;

endpackage

// ===== hdl/tilt_to_button_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_to_button_detector_unit
// Turns X/Y tilt levels into press and release events, one machine per axis.
// Result: registered in out_r, or in skid_r while out_r is held by out_stall.
// Throughput: one transaction per cycle unless in_stall; a two-entry output
// stage (result plus skid register) keeps input open while one result waits.
// Reset: synchronous active-low rst_n; thresholds to defaults, axes to check,
// kept levels to 128, output stage empty.
// ----------------------------------------------------------------------------
module tilt_to_button_detector_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ttb_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ttb_pkg::LVL_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_sample_ok,
  input  logic [ttb_pkg::LVL_W-1:0]    in_x_level,
  input  logic [ttb_pkg::LVL_W-1:0]    in_y_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ttb_pkg::EV_W-1:0]     out_x_event,
  output logic [ttb_pkg::EV_W-1:0]     out_y_event,
  output logic [ttb_pkg::LVL_W-1:0]    out_x_now,
  output logic [ttb_pkg::LVL_W-1:0]    out_y_now
);

  ttb_pkg::lvl_t    regs_r [ttb_pkg::NUM_REGS];
  ttb_pkg::lvl_t    x_kept_r, y_kept_r;
  ttb_pkg::lvl_t    x_lvl, y_lvl;
  ttb_pkg::axis_cfg_t x_cfg, y_cfg;
  ttb_pkg::ev_t     x_ev, y_ev;
  ttb_pkg::result_t res_nxt, out_r, skid_r;
  logic             out_vld_r, skid_vld_r;
  logic             accept, take;

  assign in_stall = skid_vld_r;
  assign accept   = in_valid && !in_stall;
  assign take     = out_vld_r && !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[ttb_pkg::REG_X_LOW_ENTER]    <= ttb_pkg::RST_X_LOW_ENTER;
      regs_r[ttb_pkg::REG_X_HIGH_ENTER]   <= ttb_pkg::RST_X_HIGH_ENTER;
      regs_r[ttb_pkg::REG_X_LOW_CONFIRM]  <= ttb_pkg::RST_X_LOW_CONFIRM;
      regs_r[ttb_pkg::REG_X_HIGH_CONFIRM] <= ttb_pkg::RST_X_HIGH_CONFIRM;
      regs_r[ttb_pkg::REG_Y_LOW_ENTER]    <= ttb_pkg::RST_Y_LOW_ENTER;
      regs_r[ttb_pkg::REG_Y_HIGH_ENTER]   <= ttb_pkg::RST_Y_HIGH_ENTER;
      regs_r[ttb_pkg::REG_Y_LOW_CONFIRM]  <= ttb_pkg::RST_Y_LOW_CONFIRM;
      regs_r[ttb_pkg::REG_Y_HIGH_CONFIRM] <= ttb_pkg::RST_Y_HIGH_CONFIRM;
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  assign x_cfg = '{lo_enter: regs_r[ttb_pkg::REG_X_LOW_ENTER],
                   hi_enter: regs_r[ttb_pkg::REG_X_HIGH_ENTER],
                   lo_conf:  regs_r[ttb_pkg::REG_X_LOW_CONFIRM],
                   hi_conf:  regs_r[ttb_pkg::REG_X_HIGH_CONFIRM],
                   neg_rel:  ttb_pkg::X_NEG_RELEASE,
                   pos_rel:  ttb_pkg::X_POS_RELEASE};
  assign y_cfg = '{lo_enter: regs_r[ttb_pkg::REG_Y_LOW_ENTER],
                   hi_enter: regs_r[ttb_pkg::REG_Y_HIGH_ENTER],
                   lo_conf:  regs_r[ttb_pkg::REG_Y_LOW_CONFIRM],
                   hi_conf:  regs_r[ttb_pkg::REG_Y_HIGH_CONFIRM],
                   neg_rel:  ttb_pkg::Y_NEG_RELEASE,
                   pos_rel:  ttb_pkg::Y_POS_RELEASE};

  // failed read reuses kept levels
  assign x_lvl = in_sample_ok ? in_x_level : x_kept_r;
  assign y_lvl = in_sample_ok ? in_y_level : y_kept_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_kept_r <= ttb_pkg::LEVEL_CENTER;
      y_kept_r <= ttb_pkg::LEVEL_CENTER;
    end else if (accept) begin
      x_kept_r <= x_lvl;
      y_kept_r <= y_lvl;
    end
  end

  ttb_axis u_x_axis (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (accept),
    .lvl   (x_lvl),
    .acfg  (x_cfg),
    .ev    (x_ev)
  );

  ttb_axis u_y_axis (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (accept),
    .lvl   (y_lvl),
    .acfg  (y_cfg),
    .ev    (y_ev)
  );

  assign res_nxt = '{x_event: x_ev, y_event: y_ev, x_now: x_lvl, y_now: y_lvl};

  // output stage with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || take) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= accept;
      end
    end else if (accept) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || take) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res_nxt;
      end
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_x_event = out_r.x_event;
  assign out_y_event = out_r.y_event;
  assign out_x_now   = out_r.x_now;
  assign out_y_now   = out_r.y_now;

endmodule

// ===== hdl/ttb_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_axis
// One axis tilt machine: enter, confirm, press and hysteresis release.
// ----------------------------------------------------------------------------
module ttb_axis (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  ttb_pkg::lvl_t      lvl,
  input  ttb_pkg::axis_cfg_t acfg,
  output ttb_pkg::ev_t       ev
);

  ttb_pkg::mode_t mode_r;
  ttb_pkg::mode_t mode_nxt;

  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      ttb_pkg::MODE_NEG_CONF: begin
        mode_nxt = (lvl < acfg.lo_conf) ? ttb_pkg::MODE_NEG_REL : ttb_pkg::MODE_CHECK;
      end
      ttb_pkg::MODE_NEG_REL: begin
        if (lvl > acfg.neg_rel) mode_nxt = ttb_pkg::MODE_CHECK;
      end
      ttb_pkg::MODE_POS_CONF: begin
        mode_nxt = (lvl > acfg.hi_conf) ? ttb_pkg::MODE_POS_REL : ttb_pkg::MODE_CHECK;
      end
      ttb_pkg::MODE_POS_REL: begin
        if (lvl < acfg.pos_rel) mode_nxt = ttb_pkg::MODE_CHECK;
      end
      default: begin
        priority if (lvl < acfg.lo_enter) mode_nxt = ttb_pkg::MODE_NEG_CONF;
        else if (lvl > acfg.hi_enter)     mode_nxt = ttb_pkg::MODE_POS_CONF;
        else                              mode_nxt = ttb_pkg::MODE_CHECK;
      end
    endcase
  end

  always_comb begin
    ev = ttb_pkg::EV_NONE;
    unique case (mode_r)
      ttb_pkg::MODE_NEG_CONF: if (lvl < acfg.lo_conf) ev = ttb_pkg::EV_NEG_PR;
      ttb_pkg::MODE_NEG_REL:  if (lvl > acfg.neg_rel) ev = ttb_pkg::EV_NEG_REL;
      ttb_pkg::MODE_POS_CONF: if (lvl > acfg.hi_conf) ev = ttb_pkg::EV_POS_PR;
      ttb_pkg::MODE_POS_REL:  if (lvl < acfg.pos_rel) ev = ttb_pkg::EV_POS_REL;
      default:                ev = ttb_pkg::EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ttb_pkg::MODE_CHECK;
    end else if (adv) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ===== hdl/ttb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_checker
// Port-level checks for the tilt-to-button detector, bound to the top level.
// ----------------------------------------------------------------------------
module ttb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ttb_pkg::EV_W-1:0]     out_x_event,
  input logic [ttb_pkg::EV_W-1:0]     out_y_event,
  input logic [ttb_pkg::LVL_W-1:0]    out_x_now,
  input logic [ttb_pkg::LVL_W-1:0]    out_y_now
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_event) &&
      $stable(out_y_event) && $stable(out_x_now) && $stable(out_y_now))
    else $error("stalled transaction changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_x_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_event != ttb_pkg::EV_NEG_REL ||
                   out_x_now > ttb_pkg::X_NEG_RELEASE) &&
                  (out_x_event != ttb_pkg::EV_POS_REL ||
                   out_x_now < ttb_pkg::X_POS_RELEASE))
    else $error("X release outside hysteresis level");

  a_y_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_y_event != ttb_pkg::EV_NEG_REL ||
                   out_y_now > ttb_pkg::Y_NEG_RELEASE) &&
                  (out_y_event != ttb_pkg::EV_POS_REL ||
                   out_y_now < ttb_pkg::Y_POS_RELEASE))
    else $error("Y release outside hysteresis level");

endmodule

bind tilt_to_button_detector_unit ttb_checker u_ttb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_x_event (out_x_event),
  .out_y_event (out_y_event),
  .out_x_now   (out_x_now),
  .out_y_now   (out_y_now)
);

// ===== verif/tilt_to_button_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_to_button_detector_unit_tb
// Self-checking bench for the tilt-to-button detector. A directed table hits
// the threshold edges, both press/release paths per axis and failed reads,
// then random samples biased toward the thresholds run under several
// threshold settings. Every result transaction is checked against the typed
// table row or an in-bench model of the two axis machines. Both sides idle
// at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tilt_to_button_detector_unit_tb;

  localparam int CLK_HALF       = 1;
  localparam int RESET_CYCLES   = 6;
  localparam int DIR_ROWS       = 22;
  localparam int RAND_PER_PHASE = 150;
  localparam int NUM_PHASES     = 7;
  localparam int IDLE_PCT       = 10;
  localparam int BAD_READ_PCT   = 15;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 80;
  localparam int QUIET_FIRST    = 500;
  localparam int QUIET_LAST     = 700;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    PH_RESET_VALUES,
    PH_ALL_ONES,
    PH_ALL_ZEROS,
    PH_RANDOM_A,
    PH_OVERLAP,
    PH_DEFAULTS,
    PH_RANDOM_B
  } phase_t;

  typedef struct packed {
    ttb_pkg::mode_t mode;
    ttb_pkg::ev_t   ev;
  } axis_next_t;

  typedef struct packed {
    logic             ok;
    ttb_pkg::lvl_t    x;
    ttb_pkg::lvl_t    y;
    logic             typed;
    ttb_pkg::result_t want;
  } dir_row_t;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      cfg_we       = 1'b0;
  logic [ttb_pkg::IDX_W-1:0] cfg_index    = ttb_pkg::REG_X_LOW_ENTER;
  ttb_pkg::lvl_t             cfg_data     = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic                      in_sample_ok = 1'b0;
  ttb_pkg::lvl_t             in_x_level   = ttb_pkg::LEVEL_CENTER;
  ttb_pkg::lvl_t             in_y_level   = ttb_pkg::LEVEL_CENTER;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  ttb_pkg::ev_t              out_x_event;
  ttb_pkg::ev_t              out_y_event;
  ttb_pkg::lvl_t             out_x_now;
  ttb_pkg::lvl_t             out_y_now;

  ttb_pkg::lvl_t rst_thr [ttb_pkg::NUM_REGS] = '{
    ttb_pkg::RST_X_LOW_ENTER, ttb_pkg::RST_X_HIGH_ENTER,
    ttb_pkg::RST_X_LOW_CONFIRM, ttb_pkg::RST_X_HIGH_CONFIRM,
    ttb_pkg::RST_Y_LOW_ENTER, ttb_pkg::RST_Y_HIGH_ENTER,
    ttb_pkg::RST_Y_LOW_CONFIRM, ttb_pkg::RST_Y_HIGH_CONFIRM};
  ttb_pkg::lvl_t    thr [ttb_pkg::NUM_REGS];
  ttb_pkg::mode_t   x_mode;
  ttb_pkg::mode_t   y_mode;
  ttb_pkg::lvl_t    x_kept;
  ttb_pkg::lvl_t    y_kept;
  ttb_pkg::result_t pending_results [$];
  ttb_pkg::result_t want;
  int               errors       = 0;
  int               items_sent   = 0;
  int               results_seen = 0;
  int               hold_left    = 0;
  bit               hold_done    = 1'b0;
  int               idle_cycles  = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{1'b1, 8'd128, 8'd128, 1'b1,
      '{ttb_pkg::EV_NONE, ttb_pkg::EV_NONE, 8'd128, 8'd128}},
    '{1'b1, 8'd0, 8'd0, 1'b1,
      '{ttb_pkg::EV_NONE, ttb_pkg::EV_NONE, 8'd0, 8'd0}},
    '{1'b1, 8'd0, 8'd0, 1'b1,
      '{ttb_pkg::EV_NEG_PR, ttb_pkg::EV_NEG_PR, 8'd0, 8'd0}},
    '{1'b0, 8'd255, 8'd255, 1'b1,
      '{ttb_pkg::EV_NONE, ttb_pkg::EV_NONE, 8'd0, 8'd0}},
    '{1'b1, 8'd116, 8'd103, 1'b1,
      '{ttb_pkg::EV_NEG_REL, ttb_pkg::EV_NEG_REL, 8'd116, 8'd103}},
    '{1'b1, 8'd255, 8'd255, 1'b1,
      '{ttb_pkg::EV_NONE, ttb_pkg::EV_NONE, 8'd255, 8'd255}},
    '{1'b1, 8'd255, 8'd255, 1'b1,
      '{ttb_pkg::EV_POS_PR, ttb_pkg::EV_POS_PR, 8'd255, 8'd255}},
    '{1'b1, 8'd161, 8'd161, 1'b1,
      '{ttb_pkg::EV_NONE, ttb_pkg::EV_NONE, 8'd161, 8'd161}},
    '{1'b1, 8'd160, 8'd160, 1'b1,
      '{ttb_pkg::EV_POS_REL, ttb_pkg::EV_POS_REL, 8'd160, 8'd160}},
    '{1'b1, 8'd68,  8'd63,  1'b0, '0},
    '{1'b1, 8'd56,  8'd51,  1'b0, '0},
    '{1'b1, 8'd69,  8'd64,  1'b0, '0},
    '{1'b1, 8'd213, 8'd193, 1'b0, '0},
    '{1'b1, 8'd218, 8'd205, 1'b0, '0},
    '{1'b1, 8'd212, 8'd192, 1'b0, '0},
    '{1'b0, 8'd0, 8'd0, 1'b1,
      '{ttb_pkg::EV_NONE, ttb_pkg::EV_NONE, 8'd212, 8'd192}},
    '{1'b1, 8'hAA,  8'h55,  1'b0, '0},
    '{1'b1, 8'h55,  8'hAA,  1'b0, '0},
    '{1'b1, 8'd0,   8'd255, 1'b0, '0},
    '{1'b1, 8'd0, 8'd255, 1'b1,
      '{ttb_pkg::EV_NEG_PR, ttb_pkg::EV_POS_PR, 8'd0, 8'd255}},
    '{1'b0, 8'd255, 8'd0, 1'b1,
      '{ttb_pkg::EV_NONE, ttb_pkg::EV_NONE, 8'd0, 8'd255}},
    '{1'b1, 8'd200, 8'd50, 1'b1,
      '{ttb_pkg::EV_NEG_REL, ttb_pkg::EV_POS_REL, 8'd200, 8'd50}}
  };

  tilt_to_button_detector_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_ok (in_sample_ok),
    .in_x_level   (in_x_level),
    .in_y_level   (in_y_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x_event  (out_x_event),
    .out_y_event  (out_y_event),
    .out_x_now    (out_x_now),
    .out_y_now    (out_y_now)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic ttb_pkg::axis_cfg_t axis_thresholds(input bit y_axis);
    ttb_pkg::axis_cfg_t c;
    if (y_axis) begin
      c = '{thr[ttb_pkg::REG_Y_LOW_ENTER], thr[ttb_pkg::REG_Y_HIGH_ENTER],
            thr[ttb_pkg::REG_Y_LOW_CONFIRM], thr[ttb_pkg::REG_Y_HIGH_CONFIRM],
            ttb_pkg::Y_NEG_RELEASE, ttb_pkg::Y_POS_RELEASE};
    end else begin
      c = '{thr[ttb_pkg::REG_X_LOW_ENTER], thr[ttb_pkg::REG_X_HIGH_ENTER],
            thr[ttb_pkg::REG_X_LOW_CONFIRM], thr[ttb_pkg::REG_X_HIGH_CONFIRM],
            ttb_pkg::X_NEG_RELEASE, ttb_pkg::X_POS_RELEASE};
    end
    return c;
  endfunction

  function automatic axis_next_t advance_axis(input ttb_pkg::mode_t mode,
                                              input ttb_pkg::lvl_t lvl,
                                              input ttb_pkg::axis_cfg_t c);
    axis_next_t n;
    n.mode = mode;
    n.ev   = ttb_pkg::EV_NONE;
    case (mode)
      ttb_pkg::MODE_NEG_CONF: begin
        if (lvl < c.lo_conf) begin
          n.mode = ttb_pkg::MODE_NEG_REL;
          n.ev   = ttb_pkg::EV_NEG_PR;
        end else begin
          n.mode = ttb_pkg::MODE_CHECK;
        end
      end
      ttb_pkg::MODE_NEG_REL: begin
        if (lvl > c.neg_rel) begin
          n.mode = ttb_pkg::MODE_CHECK;
          n.ev   = ttb_pkg::EV_NEG_REL;
        end
      end
      ttb_pkg::MODE_POS_CONF: begin
        if (lvl > c.hi_conf) begin
          n.mode = ttb_pkg::MODE_POS_REL;
          n.ev   = ttb_pkg::EV_POS_PR;
        end else begin
          n.mode = ttb_pkg::MODE_CHECK;
        end
      end
      ttb_pkg::MODE_POS_REL: begin
        if (lvl < c.pos_rel) begin
          n.mode = ttb_pkg::MODE_CHECK;
          n.ev   = ttb_pkg::EV_POS_REL;
        end
      end
      default: begin
        if (lvl < c.lo_enter) n.mode = ttb_pkg::MODE_NEG_CONF;
        else if (lvl > c.hi_enter) n.mode = ttb_pkg::MODE_POS_CONF;
        else n.mode = ttb_pkg::MODE_CHECK;
      end
    endcase
    return n;
  endfunction

  function automatic ttb_pkg::result_t predict_buttons(input logic ok,
                                                       input ttb_pkg::lvl_t x,
                                                       input ttb_pkg::lvl_t y);
    axis_next_t       xn;
    axis_next_t       yn;
    ttb_pkg::result_t r;
    if (ok) begin
      x_kept = x;
      y_kept = y;
    end
    xn = advance_axis(x_mode, x_kept, axis_thresholds(1'b0));
    yn = advance_axis(y_mode, y_kept, axis_thresholds(1'b1));
    x_mode    = xn.mode;
    y_mode    = yn.mode;
    r.x_event = xn.ev;
    r.y_event = yn.ev;
    r.x_now   = x_kept;
    r.y_now   = y_kept;
    return r;
  endfunction

  // Repeats favor two-sample confirms; some picks are uniform, the rest land near a threshold.
  function automatic ttb_pkg::lvl_t pick_level(input ttb_pkg::lvl_t prev,
                                               input ttb_pkg::axis_cfg_t c);
    int r;
    int v;
    r = int'($urandom_range(99));
    if (r < 35) return prev;
    if (r < 50) return ttb_pkg::lvl_t'($urandom_range(255));
    case ($urandom_range(5))
      0:       v = int'(c.lo_enter);
      1:       v = int'(c.hi_enter);
      2:       v = int'(c.lo_conf);
      3:       v = int'(c.hi_conf);
      4:       v = int'(c.neg_rel);
      default: v = int'(c.pos_rel);
    endcase
    v = v + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return ttb_pkg::lvl_t'(v);
  endfunction

  task automatic offer_sample(input logic ok, input ttb_pkg::lvl_t x,
                              input ttb_pkg::lvl_t y, input logic typed,
                              input ttb_pkg::result_t typed_want);
    ttb_pkg::result_t modeled;
    bit               quiet;
    int               gap;
    quiet = (items_sent >= QUIET_FIRST) && (items_sent < QUIET_LAST);
    gap   = (quiet || $urandom_range(99) >= IDLE_PCT) ? 0 : int'($urandom_range(4, 1));
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_ok <= ok;
    in_x_level   <= x;
    in_y_level   <= y;
    do @(posedge clk); while (in_stall);
    modeled = predict_buttons(ok, x, y);
    pending_results.push_back(typed ? typed_want : modeled);
    items_sent++;
  endtask

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned act);
    if (expv != act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, act);
    end
  endtask

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d %0d",
                   $time, out_x_event, out_y_event, out_x_now, out_y_now);
        end else begin
          want = pending_results.pop_front();
          check_field("x_event", 32'(want.x_event), 32'(out_x_event));
          check_field("y_event", 32'(want.y_event), 32'(out_y_event));
          check_field("x_now", 32'(want.x_now), 32'(out_x_now));
          check_field("y_now", 32'(want.y_now), 32'(out_y_now));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog timeout, %0d transactions outstanding", $time,
               pending_results.size());
      $display("FAIL tilt_to_button_detector_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ttb_pkg::lvl_t x_lvl;
    ttb_pkg::lvl_t y_lvl;
    ttb_pkg::lvl_t v;
    logic          ok;
    bit            low_reg;
    thr    = rst_thr;
    x_mode = ttb_pkg::MODE_CHECK;
    y_mode = ttb_pkg::MODE_CHECK;
    x_kept = ttb_pkg::LEVEL_CENTER;
    y_kept = ttb_pkg::LEVEL_CENTER;
    x_lvl  = ttb_pkg::LEVEL_CENTER;
    y_lvl  = ttb_pkg::LEVEL_CENTER;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[r]) begin
      offer_sample(dir_table[r].ok, dir_table[r].x, dir_table[r].y,
                   dir_table[r].typed, dir_table[r].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (phase_t'(ph) != PH_RESET_VALUES) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        for (int i = 0; i < ttb_pkg::NUM_REGS; i++) begin
          low_reg = (i == int'(ttb_pkg::REG_X_LOW_ENTER)) ||
                    (i == int'(ttb_pkg::REG_X_LOW_CONFIRM)) ||
                    (i == int'(ttb_pkg::REG_Y_LOW_ENTER)) ||
                    (i == int'(ttb_pkg::REG_Y_LOW_CONFIRM));
          case (phase_t'(ph))
            PH_ALL_ONES:  v = 8'hFF;
            PH_ALL_ZEROS: v = 8'h00;
            PH_OVERLAP:   v = low_reg ? ttb_pkg::lvl_t'($urandom_range(255, 150))
                                      : ttb_pkg::lvl_t'($urandom_range(110, 0));
            PH_DEFAULTS:  v = rst_thr[i];
            default:      v = ttb_pkg::lvl_t'($urandom_range(255));
          endcase
          cfg_we    <= 1'b1;
          cfg_index <= ttb_pkg::IDX_W'(i);
          cfg_data  <= v;
          @(posedge clk);
          thr[i] = v;
        end
        cfg_we <= 1'b0;
      end
      repeat (RAND_PER_PHASE) begin
        ok    = ($urandom_range(99) >= BAD_READ_PCT);
        x_lvl = pick_level(x_lvl, axis_thresholds(1'b0));
        y_lvl = pick_level(y_lvl, axis_thresholds(1'b1));
        offer_sample(ok, x_lvl, y_lvl, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS tilt_to_button_detector_unit");
    end else begin
      $display("FAIL tilt_to_button_detector_unit");
    end
    $finish;
  end

endmodule
